// ----- hw/rtl/b64s_pkg.sv -----
// Shared types, constants and character mapping functions for the base64url codec.
package b64s_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
  localparam logic [7:0] ASCII_DIGIT_0 = 8'h30;
  localparam logic [7:0] ASCII_DIGIT_9 = 8'h39;
  localparam logic [7:0] ASCII_DASH    = 8'h2D;
  localparam logic [7:0] ASCII_UNDER   = 8'h5F;

  localparam logic [5:0] SYM_LOWER_BASE = 6'd26;
  localparam logic [5:0] SYM_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SYM_DASH       = 6'd62;
  localparam logic [5:0] SYM_UNDER      = 6'd63;

  typedef struct packed {
    logic [7:0] data_in;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_value;
    logic       out_valid;
    logic       last_out;
    logic       error;
  } out_item_t;

  typedef struct packed {
    out_item_t first;
    out_item_t second;
    logic      two;
  } job_t;

  function automatic logic [7:0] enc_char(input logic [5:0] six);
    logic [7:0] ext;
    ext = {2'b00, six};
    if (six < SYM_LOWER_BASE) begin
      return ASCII_UPPER_A + ext;
    end else if (six < SYM_DIGIT_BASE) begin
      return ASCII_LOWER_A + (ext - {2'b00, SYM_LOWER_BASE});
    end else if (six < SYM_DASH) begin
      return ASCII_DIGIT_0 + (ext - {2'b00, SYM_DIGIT_BASE});
    end else if (six == SYM_DASH) begin
      return ASCII_DASH;
    end else begin
      return ASCII_UNDER;
    end
  endfunction

  // Bit 6 flags a character outside the alphabet.
  function automatic logic [6:0] sym_dec(input logic [7:0] ch);
    logic [7:0] off;
    off = 8'h00;
    if (ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_Z) begin
      off = ch - ASCII_UPPER_A;
      return {1'b0, off[5:0]};
    end else if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z) begin
      off = ch - ASCII_LOWER_A + {2'b00, SYM_LOWER_BASE};
      return {1'b0, off[5:0]};
    end else if (ch >= ASCII_DIGIT_0 && ch <= ASCII_DIGIT_9) begin
      off = ch - ASCII_DIGIT_0 + {2'b00, SYM_DIGIT_BASE};
      return {1'b0, off[5:0]};
    end else if (ch == ASCII_DASH) begin
      return {1'b0, SYM_DASH};
    end else if (ch == ASCII_UNDER) begin
      return {1'b0, SYM_UNDER};
    end else begin
      return {1'b1, off[5:0]};
    end
  endfunction

endpackage

// ----- hw/rtl/b64s_front.sv -----
// Front end: accepts items, tracks group state and builds result jobs.
module b64s_front import b64s_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_mode,
  input  logic     accept,
  input  in_item_t item,
  output logic     job_push,
  output job_t     job
);

  logic       mode_r, mode_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [5:0] carry_r, carry_nxt;
  logic [2:0] ccnt_r, ccnt_nxt;
  logic       err_r, err_nxt;

  logic [7:0]  d;
  logic [6:0]  sym;
  logic        nerr;
  logic [1:0]  nph;
  logic        emit;
  logic [7:0]  byte_v;
  out_item_t   status;
  out_item_t   blank;

  assign d = item.data_in;
  assign sym = sym_dec(d);

  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    carry_nxt = carry_r;
    ccnt_nxt  = ccnt_r;
    err_nxt   = err_r;
    blank     = '{out_value: 8'h00, out_valid: 1'b0, last_out: 1'b0, error: 1'b0};
    job       = '{first: blank, second: blank, two: 1'b0};
    job_push  = 1'b0;
    nerr      = err_r | sym[6];
    nph       = phase_r + 2'd1;
    emit      = 1'b0;
    byte_v    = 8'h00;
    status    = '{out_value: 8'h00, out_valid: 1'b0, last_out: 1'b1,
                  error: nerr | (nph == 2'd1)};

    if (cfg_we) begin
      mode_nxt  = cfg_mode;
      phase_nxt = '0;
      carry_nxt = '0;
      ccnt_nxt  = '0;
      err_nxt   = 1'b0;
    end else if (accept && !mode_r) begin
      job_push = 1'b1;
      job.first.out_valid  = 1'b1;
      job.second.out_valid = 1'b1;
      case (phase_r)
        2'd0: begin
          job.first.out_value = enc_char(d[7:2]);
          carry_nxt = {4'b0000, d[1:0]};
          ccnt_nxt  = 3'd2;
          phase_nxt = 2'd1;
        end
        2'd1: begin
          job.first.out_value = enc_char({carry_r[1:0], d[7:4]});
          carry_nxt = {2'b00, d[3:0]};
          ccnt_nxt  = 3'd4;
          phase_nxt = 2'd2;
        end
        default: begin
          job.first.out_value  = enc_char({carry_r[3:0], d[7:6]});
          job.second.out_value = enc_char(d[5:0]);
          job.two   = 1'b1;
          carry_nxt = '0;
          ccnt_nxt  = '0;
          phase_nxt = 2'd0;
        end
      endcase
      if (item.last_in) begin
        if (ccnt_nxt == 3'd2) begin
          job.second.out_value = enc_char({carry_nxt[1:0], 4'b0000});
        end else if (ccnt_nxt == 3'd4) begin
          job.second.out_value = enc_char({carry_nxt[3:0], 2'b00});
        end
        job.two             = 1'b1;
        job.second.last_out = 1'b1;
        phase_nxt = '0;
        carry_nxt = '0;
        ccnt_nxt  = '0;
        err_nxt   = 1'b0;
      end
    end else if (accept) begin
      phase_nxt = nph;
      err_nxt   = nerr;
      if (!nerr) begin
        case (ccnt_r)
          3'd6: begin
            emit      = 1'b1;
            byte_v    = {carry_r, sym[5:4]};
            carry_nxt = {2'b00, sym[3:0]};
            ccnt_nxt  = 3'd4;
          end
          3'd4: begin
            emit      = 1'b1;
            byte_v    = {carry_r[3:0], sym[5:2]};
            carry_nxt = {4'b0000, sym[1:0]};
            ccnt_nxt  = 3'd2;
          end
          3'd2: begin
            emit      = 1'b1;
            byte_v    = {carry_r[1:0], sym[5:0]};
            carry_nxt = '0;
            ccnt_nxt  = 3'd0;
          end
          default: begin
            carry_nxt = sym[5:0];
            ccnt_nxt  = 3'd6;
          end
        endcase
      end
      if (emit) begin
        job.first = '{out_value: byte_v, out_valid: 1'b1, last_out: 1'b0, error: 1'b0};
        job.second = status;
        job.two   = item.last_in;
        job_push  = 1'b1;
      end else if (item.last_in) begin
        job.first = status;
        job_push  = 1'b1;
      end
      if (item.last_in) begin
        phase_nxt = '0;
        carry_nxt = '0;
        ccnt_nxt  = '0;
        err_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      phase_r <= '0;
      carry_r <= '0;
      ccnt_r  <= '0;
      err_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
      ccnt_r  <= ccnt_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ----- hw/rtl/b64s_queue.sv -----
// Job queue between the front end and the result sequencer.
module b64s_queue import b64s_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wdata,
  output logic full,
  input  logic pop,
  output job_t rdata,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- hw/rtl/b64s_back.sv -----
// Result sequencer: unpacks jobs into single items on the output register.
module b64s_back import b64s_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      job,
  input  logic      job_empty,
  output logic      job_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_data
);

  out_item_t out_r, out_nxt;
  logic      ov_r, ov_nxt;
  out_item_t sec_r, sec_nxt;
  logic      sv_r, sv_nxt;
  logic      load_en;

  assign load_en   = !ov_r || out_pop;
  assign out_empty = !ov_r;
  assign out_data  = out_r;
  assign job_pop   = load_en && !sv_r && !job_empty;

  always_comb begin
    out_nxt = out_r;
    ov_nxt  = ov_r;
    sec_nxt = sec_r;
    sv_nxt  = sv_r;
    if (load_en) begin
      if (sv_r) begin
        out_nxt = sec_r;
        ov_nxt  = 1'b1;
        sv_nxt  = 1'b0;
      end else if (!job_empty) begin
        out_nxt = job.first;
        ov_nxt  = 1'b1;
        sec_nxt = job.second;
        sv_nxt  = job.two;
      end else begin
        ov_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    sec_r <= sec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      sv_r <= sv_nxt;
    end
  end

endmodule

// ----- hw/rtl/base64url_stream_codec.sv -----
// Top level of the streaming base64url codec (unpadded URL alphabet).
// A result passes through the job queue and then the output register to the output ports.
// Throughput: one item per cycle for single-result items while results are popped;
// a second result waits in the sequencer for the single output register.
// Reset (synchronous, active low) selects encode mode and empties the job queue.
module base64url_stream_codec import b64s_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  logic accept;
  logic job_push, q_full, q_empty, q_pop;
  job_t job_w, job_rd;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign accept    = in_push && !q_full;

  b64s_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_mode (cfg_data),
    .accept   (accept),
    .item     (in_data),
    .job_push (job_push),
    .job      (job_w)
  );

  b64s_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_w),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (job_rd),
    .empty (q_empty)
  );

  b64s_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job_rd),
    .job_empty (q_empty),
    .job_pop   (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

// ----- hw/rtl/b64s_checker.sv -----
// Port-level assertions for the base64url codec and their bind to the top level.
module b64s_checker import b64s_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_empty,
  input logic      out_pop,
  input out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_error_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.error) |-> out_data.last_out)
    else $error("error flag on a non-final item");

  a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.out_valid) |->
      (out_data.last_out && out_data.out_value == 8'h00))
    else $error("malformed status item");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("stalled result item changed");

endmodule

bind base64url_stream_codec b64s_checker u_b64s_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
